// File: sv/sbbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbbp_pkg;

  // Width of the occupancy line and of its three 32-bit words.
  localparam int unsigned MaskW     = 96;
  localparam int unsigned MaskWordW = 32;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CountW    = 32;

  // Result kinds.
  localparam logic KindEntry = 1'b0;
  localparam logic KindLine  = 1'b1;

  // One input beat: an index entry and the stream end flag.
  typedef struct packed {
    logic [WordW-1:0] entry_low_word;
    logic [WordW-1:0] entry_high_word;
    logic             end_of_stream;
  } entry_t;

  // One output beat: a replayed entry or a bitmap line.
  typedef struct packed {
    logic                 result_kind;
    logic [WordW-1:0]     data_low_word;
    logic [WordW-1:0]     data_high_word;
    logic [CountW-1:0]    prior_block_count;
    logic [MaskWordW-1:0] mask_bits_low;
    logic [MaskWordW-1:0] mask_bits_mid;
    logic [MaskWordW-1:0] mask_bits_high;
    logic                 run_last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_open;    // input may be accepted
    logic rd_first;   // issue the buffer read of the first entry
    logic replay;     // emit the buffered entry and fetch the next one
    logic emit_line;  // emit the bitmap line and restart it
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;        // accepted beat closes the block
    logic close_nz;     // the closing block is nonzero
    logic close_line;   // the closing block completes or flushes a line
    logic replay_more;  // more buffered entries follow the current one
    logic line_due;     // a line follows the current replay
    logic slot_free;    // output register can take a result this cycle
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: sv/sbbp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one payload per beat.
interface sbbp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/sparse_block_bitmap_packer_top.sv
// Channel   Dir  Payload             Beat
// entry_i   in   sbbp_pkg::entry_t   one 128-bit index entry plus stream end flag
// result_o  out  sbbp_pkg::result_t  one replayed entry or one 96-bit bitmap line
//
// Entries are taken one per cycle while a block fills.
// A closing nonzero block holds the input in the prime state and while its N entries
// are replayed from the single-port-read block buffer, then in the line state if a line is due.
// A closing zero block without a line does not hold the input.
// Output stalls hold the replay; rst_ni clears all control state asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module sparse_block_bitmap_packer_top #(
  parameter int unsigned ENTRIES_PER_BLOCK = 32,
  parameter int unsigned BLOCKS_PER_LINE   = 96
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sbbp_stream_if.sink   entry_i,
  sbbp_stream_if.source result_o
);

  sbbp_pkg::ctrl_cmd_t    cmd;
  sbbp_pkg::ctrl_status_t status;

  // Sequencer.
  sbbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Buffer, line state and output register.
  sbbp_datapath #(
    .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK),
    .BLOCKS_PER_LINE   (BLOCKS_PER_LINE)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (entry_i),
    .result_o (result_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire

// File: sv/sbbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sbbp_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]               wdata_i,
  input  wire logic                           re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/sbbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: fill a block, replay it if nonzero, then emit a line if due.
module sbbp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sbbp_pkg::ctrl_status_t status_i,
  output      sbbp_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StFill,
    StPrime,
    StReplay,
    StLine
  } state_e;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StFill: begin
        if (status_i.close) begin
          if (status_i.close_nz) begin
            state_d = StPrime;
          end else if (status_i.close_line) begin
            state_d = StLine;
          end
        end
      end
      StPrime: begin
        state_d = StReplay;
      end
      StReplay: begin
        if (status_i.slot_free && !status_i.replay_more) begin
          state_d = status_i.line_due ? StLine : StFill;
        end
      end
      StLine: begin
        if (status_i.slot_free) begin
          state_d = StFill;
        end
      end
      default: begin
        state_d = StFill;
      end
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.in_open   = (state_q == StFill);
    cmd_o.rd_first  = (state_q == StPrime);
    cmd_o.replay    = (state_q == StReplay) && status_i.slot_free;
    cmd_o.emit_line = (state_q == StLine) && status_i.slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFill;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/sbbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

// Block buffer, occupancy line, block counters and output register.
module sbbp_datapath #(
  parameter int unsigned ENTRIES_PER_BLOCK = 32,
  parameter int unsigned BLOCKS_PER_LINE   = 96
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sbbp_stream_if.sink                entry_i,
  sbbp_stream_if.source              result_o,
  input  wire sbbp_pkg::ctrl_cmd_t    cmd_i,
  output      sbbp_pkg::ctrl_status_t status_o
);

  localparam int unsigned AddrW  = ENTRIES_PER_BLOCK > 1 ? $clog2(ENTRIES_PER_BLOCK) : 1;
  localparam int unsigned CntW   = $clog2(ENTRIES_PER_BLOCK + 1);
  localparam int unsigned BitW   = $clog2(BLOCKS_PER_LINE + 1);
  localparam int unsigned MaskW  = sbbp_pkg::MaskW;
  localparam int unsigned WordW  = sbbp_pkg::WordW;
  localparam int unsigned CountW = sbbp_pkg::CountW;
  localparam int unsigned MWordW = sbbp_pkg::MaskWordW;

  sbbp_pkg::entry_t  in_beat;
  sbbp_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   held_q, held_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   idx_inc;
  logic              nz_q, nz_d;
  logic              last_q, last_d;
  logic              line_due_q, line_due_d;
  logic [BitW-1:0]   bitpos_q, bitpos_d;
  logic [BitW-1:0]   bitpos_inc;
  logic [MaskW-1:0]  mask_q, mask_d;
  logic [CountW-1:0] run_cnt_q, run_cnt_d;
  logic [CountW-1:0] line_start_q, line_start_d;

  logic              accept;
  logic              close;
  logic              nz_final;
  logic              close_line;
  logic              replay_more;
  logic              slot_free;

  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [2*WordW-1:0] ram_wdata;
  logic [2*WordW-1:0] ram_rdata;

  assign in_beat = entry_i.payload;

  // Input handshake and block closing conditions.
  assign entry_i.ready = cmd_i.in_open;
  assign accept        = entry_i.valid && cmd_i.in_open;
  assign nz_final      = nz_q || ((in_beat.entry_low_word | in_beat.entry_high_word) != '0);
  assign close         = accept &&
                         ((pos_q + CntW'(1) == CntW'(ENTRIES_PER_BLOCK)) || in_beat.end_of_stream);
  assign bitpos_inc    = bitpos_q + BitW'(1);
  assign close_line    = (bitpos_inc == BitW'(BLOCKS_PER_LINE)) || in_beat.end_of_stream;

  // Replay progress through the buffered entries.
  assign idx_inc     = idx_q + CntW'(1);
  assign replay_more = (idx_inc != held_q);
  assign slot_free   = !out_valid_q || result_o.ready;

  // Block buffer: written on each accepted beat, read during replay.
  assign ram_wdata = {in_beat.entry_high_word, in_beat.entry_low_word};
  assign ram_re    = cmd_i.rd_first || (cmd_i.replay && replay_more);
  assign ram_raddr = cmd_i.rd_first ? '0 : idx_inc[AddrW-1:0];

  sbbp_ram #(
    .WIDTH (2 * WordW),
    .DEPTH (ENTRIES_PER_BLOCK)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Block, line and counter state.
  always_comb begin
    pos_d        = pos_q;
    held_d       = held_q;
    idx_d        = idx_q;
    nz_d         = nz_q;
    last_d       = last_q;
    line_due_d   = line_due_q;
    bitpos_d     = bitpos_q;
    mask_d       = mask_q;
    run_cnt_d    = run_cnt_q;
    line_start_d = line_start_q;

    if (accept) begin
      if (close) begin
        pos_d      = '0;
        nz_d       = 1'b0;
        held_d     = pos_q + CntW'(1);
        last_d     = in_beat.end_of_stream;
        line_due_d = close_line;
        mask_d     = mask_q | ({{(MaskW-1){1'b0}}, nz_final} << bitpos_q);
        run_cnt_d  = run_cnt_q + CountW'(nz_final);
        bitpos_d   = bitpos_inc;
      end else begin
        pos_d = pos_q + CntW'(1);
        nz_d  = nz_final;
      end
    end

    if (cmd_i.rd_first) begin
      idx_d = '0;
    end else if (cmd_i.replay) begin
      idx_d = idx_inc;
    end

    // A line restarts the mask; stream end also clears the counts.
    if (cmd_i.emit_line) begin
      mask_d   = '0;
      bitpos_d = '0;
      if (last_q) begin
        run_cnt_d    = '0;
        line_start_d = '0;
      end else begin
        line_start_d = run_cnt_q;
      end
    end
  end

  // Output register loads.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    if (cmd_i.replay) begin
      out_d                = '0;
      out_d.result_kind    = sbbp_pkg::KindEntry;
      out_d.data_low_word  = ram_rdata[WordW-1:0];
      out_d.data_high_word = ram_rdata[2*WordW-1:WordW];
      out_d.run_last       = !replay_more && !line_due_q;
      out_valid_d          = 1'b1;
    end else if (cmd_i.emit_line) begin
      out_d                   = '0;
      out_d.result_kind       = sbbp_pkg::KindLine;
      out_d.prior_block_count = line_start_q;
      out_d.mask_bits_low     = mask_q[MWordW-1:0];
      out_d.mask_bits_mid     = mask_q[2*MWordW-1:MWordW];
      out_d.mask_bits_high    = mask_q[3*MWordW-1:2*MWordW];
      out_d.run_last          = 1'b1;
      out_valid_d             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      held_q       <= '0;
      idx_q        <= '0;
      nz_q         <= 1'b0;
      last_q       <= 1'b0;
      line_due_q   <= 1'b0;
      bitpos_q     <= '0;
      mask_q       <= '0;
      run_cnt_q    <= '0;
      line_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      held_q       <= held_d;
      idx_q        <= idx_d;
      nz_q         <= nz_d;
      last_q       <= last_d;
      line_due_q   <= line_due_d;
      bitpos_q     <= bitpos_d;
      mask_q       <= mask_d;
      run_cnt_q    <= run_cnt_d;
      line_start_q <= line_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Status to the controller.
  always_comb begin
    status_o             = '0;
    status_o.close       = close;
    status_o.close_nz    = nz_final;
    status_o.close_line  = close_line;
    status_o.replay_more = replay_more;
    status_o.line_due    = line_due_q;
    status_o.slot_free   = slot_free;
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned EntriesPerBlock = 32;
  localparam int unsigned BlocksPerLine   = 96;
  localparam int unsigned CycleLimit      = 500_000;
  localparam int unsigned TailCycles      = 40;

  // Tracks the expected replayed entries and bitmap lines of the packer.
  class bitmap_stream_scoreboard;
    logic [sbbp_pkg::WordW-1:0]  low_buf [EntriesPerBlock];
    logic [sbbp_pkg::WordW-1:0]  high_buf [EntriesPerBlock];
    bit                          block_live;
    int unsigned                 fill;
    int unsigned                 slot;
    logic [sbbp_pkg::MaskW-1:0]  occupancy;
    logic [sbbp_pkg::CountW-1:0] nonzero_blocks;
    logic [sbbp_pkg::CountW-1:0] line_base;
    sbbp_pkg::result_t           pending_beats[$];
    sbbp_pkg::result_t           staged;
    bit                          have_staged;
    int unsigned                 mismatches;

    function void clear_stream();
      block_live     = 1'b0;
      fill           = 0;
      slot           = 0;
      occupancy      = '0;
      nonzero_blocks = '0;
      line_base      = '0;
    endfunction

    // Holds the newest beat back so that the last one of an entry can be marked.
    function void stage_beat(sbbp_pkg::result_t r);
      if (have_staged) pending_beats.insert(pending_beats.size(), staged);
      staged      = r;
      have_staged = 1'b1;
    endfunction

    // Notes one accepted entry and queues the beats that it causes.
    function void take_entry(sbbp_pkg::entry_t e);
      sbbp_pkg::result_t r;
      int unsigned held;
      low_buf[fill]  = e.entry_low_word;
      high_buf[fill] = e.entry_high_word;
      if ((e.entry_low_word | e.entry_high_word) != '0) block_live = 1'b1;
      fill++;

      // A full block, or the stream end, closes the block.
      if (fill >= EntriesPerBlock || e.end_of_stream) begin
        held = fill;
        if (block_live) begin
          for (int unsigned i = 0; i < held; i++) begin
            r = '0;
            r.result_kind    = sbbp_pkg::KindEntry;
            r.data_low_word  = low_buf[i];
            r.data_high_word = high_buf[i];
            stage_beat(r);
          end
          occupancy[slot] = 1'b1;
          nonzero_blocks++;
        end
        block_live = 1'b0;
        fill       = 0;
        slot++;

        // A completed line, or a partial one at the stream end, goes out.
        if (slot >= BlocksPerLine || (e.end_of_stream && slot > 0)) begin
          r = '0;
          r.result_kind       = sbbp_pkg::KindLine;
          r.prior_block_count = line_base;
          r.mask_bits_low     = occupancy[31:0];
          r.mask_bits_mid     = occupancy[63:32];
          r.mask_bits_high    = occupancy[95:64];
          stage_beat(r);
          line_base = nonzero_blocks;
          occupancy = '0;
          slot      = 0;
        end
      end

      if (e.end_of_stream) clear_stream();

      if (have_staged) begin
        staged.run_last = 1'b1;
        pending_beats.insert(pending_beats.size(), staged);
        have_staged = 1'b0;
      end
    endfunction

    function void compare_field(string field, logic [sbbp_pkg::WordW-1:0] want,
                                logic [sbbp_pkg::WordW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", field, want, got);
        mismatches++;
      end
    endfunction

    // Checks one accepted output beat against the oldest expectation.
    function void check_beat(sbbp_pkg::result_t got);
      sbbp_pkg::result_t want;
      if (pending_beats.size() == 0) begin
        $error("unexpected output beat: kind %0d low %h high %h",
               got.result_kind, got.data_low_word, got.data_high_word);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("data_low_word", want.data_low_word, got.data_low_word);
      compare_field("data_high_word", want.data_high_word, got.data_high_word);
      compare_field("prior_block_count", want.prior_block_count, got.prior_block_count);
      compare_field("mask_bits_low", want.mask_bits_low, got.mask_bits_low);
      compare_field("mask_bits_mid", want.mask_bits_mid, got.mask_bits_mid);
      compare_field("mask_bits_high", want.mask_bits_high, got.mask_bits_high);
      compare_field("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count = 0;
  bitmap_stream_scoreboard sb;

  sbbp_stream_if #(.payload_t(sbbp_pkg::entry_t))  entry_if ();
  sbbp_stream_if #(.payload_t(sbbp_pkg::result_t)) result_if ();

  sparse_block_bitmap_packer_top #(
    .ENTRIES_PER_BLOCK(EntriesPerBlock),
    .BLOCKS_PER_LINE  (BlocksPerLine)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (entry_if),
    .result_o(result_if)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sparse_block_bitmap_packer_top regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random; beats are sampled mid-cycle, once settled.
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) sb.check_beat(result_if.payload);
  end

  // Offers one entry, with random idle cycles first, and waits for its beat.
  task automatic send_entry(input sbbp_pkg::entry_t e);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      entry_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    entry_if.valid   <= 1'b1;
    entry_if.payload <= e;
    do begin
      @(negedge clk_i);
      took = entry_if.valid && entry_if.ready;
      if (took) sb.take_entry(e);
      @(posedge clk_i);
    end while (!took);
  endtask

  // Holds the input idle until every expected beat has come out.
  task automatic wait_drained();
    entry_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_beats.size() != 0);
  endtask

  function automatic logic [sbbp_pkg::WordW-1:0] make_word();
    case ($urandom_range(3))
      0: return '0;
      1: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_entry_words(input logic [sbbp_pkg::WordW-1:0] lo,
                                  input logic [sbbp_pkg::WordW-1:0] hi,
                                  input logic last);
    sbbp_pkg::entry_t e;
    e.entry_low_word  = lo;
    e.entry_high_word = hi;
    e.end_of_stream   = last;
    send_entry(e);
  endtask

  // One stream of len entries; each block is live with the given odds.
  task automatic send_stream(input int unsigned len, input int unsigned live_pct);
    bit live;
    live = 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (i % EntriesPerBlock == 0) live = ($urandom_range(99) < live_pct);
      send_entry_words(live ? make_word() : '0, live ? make_word() : '0, i == len - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    sb = new();
    sb.clear_stream();
    sb.have_staged = 1'b0;
    sb.mismatches  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    entry_if.valid   = 1'b0;
    entry_if.payload = '0;
    result_if.ready  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 9;
          recv_stall_pct = 53;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      // Directed: single-entry streams, a zero-only stream, alternating patterns.
      if (ph == 0) begin
        send_entry_words('1, '1, 1'b1);
        send_entry_words('0, '0, 1'b1);
        send_entry_words('0, 64'd1 << 63, 1'b1);
        send_entry_words(64'd1, '0, 1'b0);
        send_entry_words('0, '0, 1'b1);
        send_entry_words({32{2'b10}}, {32{2'b01}}, 1'b0);
        send_entry_words({32{2'b01}}, {32{2'b10}}, 1'b0);
        send_entry_words('0, '0, 1'b0);
        send_entry_words('0, '0, 1'b1);
        // A full nonzero block that ends the stream.
        send_stream(EntriesPerBlock, 100);
      end

      // A full zero block followed by a partial zero block.
      if (ph == 1) send_stream(EntriesPerBlock + 3, 0);

      // Random short streams.
      sent = 0;
      while (sent < 8) begin
        len = $urandom_range(1, 8);
        send_stream(len, 70);
        sent += len;
      end

      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending_beats.size() != 0) begin
      $error("%0d expected output beats never arrived", sb.pending_beats.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("sparse_block_bitmap_packer_top regression: pass");
    end else begin
      $display("sparse_block_bitmap_packer_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sbbp_pkg.sv
sv/sbbp_stream_if.sv
sv/sbbp_ram.sv
sv/sbbp_ctrl.sv
sv/sbbp_datapath.sv
sv/sparse_block_bitmap_packer_top.sv
verif/tb_top.sv
